// ----- rtl/cna_pkg.sv -----
// Shared constants, operation codes and width helpers for the complex ALU.
package cna_pkg;

    localparam int unsigned IO_BITS       = 32;
    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned WORD_BITS_DEF = 32;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;
    localparam logic [1:0] MODE_DIV = 2'd3;

    // Divisor width: squared magnitude or the 2^F scale, whichever is wider.
    function automatic int den_bits(input int w, input int f);
        return (2 * w > f + 1) ? 2 * w : f + 1;
    endfunction

    // Remainder width: room for the shifted dividend and the top divisor shift.
    function automatic int rem_bits(input int w, input int f);
        int a;
        int b;
        a = 2 * w + 1 + f;
        b = den_bits(w, f) + w + 2;
        return ((a > b) ? a : b) + 1;
    endfunction

endpackage

// ----- rtl/cna_if.sv -----
// Request and response channel interfaces of the complex ALU.
interface cna_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          mode;
    logic signed [cna_pkg::IO_BITS-1:0]  a_real;
    logic signed [cna_pkg::IO_BITS-1:0]  a_imag;
    logic signed [cna_pkg::IO_BITS-1:0]  b_real;
    logic signed [cna_pkg::IO_BITS-1:0]  b_imag;

    modport source(output valid, mode, a_real, a_imag, b_real, b_imag, input ready);
    modport sink(input valid, mode, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cna_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [cna_pkg::IO_BITS-1:0]  res_real;
    logic signed [cna_pkg::IO_BITS-1:0]  res_imag;
    logic                                divide_by_zero;
    logic                                saturated;

    modport source(output valid, res_real, res_imag, divide_by_zero, saturated, input ready);
    modport sink(input valid, res_real, res_imag, divide_by_zero, saturated, output ready);
endinterface

// ----- rtl/cna_front.sv -----
// Front end: products, numerators and divisor, then sign and dividend magnitude.
module cna_front #(
    parameter int unsigned WORD_BITS = cna_pkg::WORD_BITS_DEF,
    parameter int unsigned FRAC_BITS = cna_pkg::FRAC_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_en,
    input  logic                                      i_valid,
    input  logic [1:0]                                i_mode,
    input  logic signed [WORD_BITS-1:0]               i_ar,
    input  logic signed [WORD_BITS-1:0]               i_ai,
    input  logic signed [WORD_BITS-1:0]               i_br,
    input  logic signed [WORD_BITS-1:0]               i_bi,
    output logic                                      o_valid,
    output logic                                      o_dz,
    output logic                                      o_neg_re,
    output logic                                      o_neg_im,
    output logic [cna_pkg::rem_bits(WORD_BITS, FRAC_BITS)-1:0] o_rem_re,
    output logic [cna_pkg::rem_bits(WORD_BITS, FRAC_BITS)-1:0] o_rem_im,
    output logic [cna_pkg::den_bits(WORD_BITS, FRAC_BITS)-1:0] o_den
);
    localparam int PW   = 2 * WORD_BITS;
    localparam int NW   = 2 * WORD_BITS + 1;
    localparam int SW   = WORD_BITS + 1;
    localparam int DENW = cna_pkg::den_bits(WORD_BITS, FRAC_BITS);
    localparam int RW   = cna_pkg::rem_bits(WORD_BITS, FRAC_BITS);

    // stage 1: products and add/sub sums
    logic                        r1_valid;
    logic [1:0]                  r1_mode;
    logic                        r1_dz;
    logic signed [WORD_BITS-1:0] r1_ar, r1_ai;
    logic signed [PW-1:0]        r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir, r1_p_bbr, r1_p_bbi;
    logic signed [SW-1:0]        r1_s_re, r1_s_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mode  <= i_mode;
            r1_dz    <= (i_mode == cna_pkg::MODE_DIV) && (i_br == '0) && (i_bi == '0);
            r1_ar    <= i_ar;
            r1_ai    <= i_ai;
            r1_p_rr  <= PW'(i_ar) * PW'(i_br);
            r1_p_ii  <= PW'(i_ai) * PW'(i_bi);
            r1_p_ri  <= PW'(i_ar) * PW'(i_bi);
            r1_p_ir  <= PW'(i_ai) * PW'(i_br);
            r1_p_bbr <= PW'(i_br) * PW'(i_br);
            r1_p_bbi <= PW'(i_bi) * PW'(i_bi);
            if (i_mode == cna_pkg::MODE_SUB) begin
                r1_s_re <= SW'(i_ar) - SW'(i_br);
                r1_s_im <= SW'(i_ai) - SW'(i_bi);
            end else begin
                r1_s_re <= SW'(i_ar) + SW'(i_br);
                r1_s_im <= SW'(i_ai) + SW'(i_bi);
            end
        end
    end

    // stage 2: numerators and divisor; every mode becomes a scaled division
    logic signed [NW-1:0] n_n_re, n_n_im;
    logic [DENW-1:0]      n_den;
    logic                 n_shift;

    always_comb begin
        n_shift = 1'b0;
        unique case (r1_mode)
            cna_pkg::MODE_ADD, cna_pkg::MODE_SUB: begin
                n_n_re = NW'(r1_s_re);
                n_n_im = NW'(r1_s_im);
                n_den  = DENW'(1);
            end
            cna_pkg::MODE_MUL: begin
                n_n_re = NW'(r1_p_rr) - NW'(r1_p_ii);
                n_n_im = NW'(r1_p_ri) + NW'(r1_p_ir);
                n_den  = DENW'(1) << FRAC_BITS;
            end
            default: begin
                if (r1_dz) begin
                    n_n_re = NW'(r1_ar);
                    n_n_im = NW'(r1_ai);
                    n_den  = DENW'(1);
                end else begin
                    n_n_re  = NW'(r1_p_rr) + NW'(r1_p_ii);
                    n_n_im  = NW'(r1_p_ir) - NW'(r1_p_ri);
                    n_den   = DENW'($unsigned(r1_p_bbr)) + DENW'($unsigned(r1_p_bbi));
                    n_shift = 1'b1;
                end
            end
        endcase
    end

    logic                 r2_valid, r2_dz, r2_shift;
    logic signed [NW-1:0] r2_n_re, r2_n_im;
    logic [DENW-1:0]      r2_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_dz    <= r1_dz;
            r2_shift <= n_shift;
            r2_n_re  <= n_n_re;
            r2_n_im  <= n_n_im;
            r2_den   <= n_den;
        end
    end

    // stage 3: sign and magnitude, scale divide numerators up by 2^F
    logic [NW-1:0] n_mag_re, n_mag_im;

    assign n_mag_re = r2_n_re[NW-1] ? NW'(-r2_n_re) : NW'(r2_n_re);
    assign n_mag_im = r2_n_im[NW-1] ? NW'(-r2_n_im) : NW'(r2_n_im);

    logic r3_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_dz     <= r2_dz;
            o_neg_re <= r2_n_re[NW-1];
            o_neg_im <= r2_n_im[NW-1];
            o_den    <= r2_den;
            if (r2_shift) begin
                o_rem_re <= RW'(n_mag_re) << FRAC_BITS;
                o_rem_im <= RW'(n_mag_im) << FRAC_BITS;
            end else begin
                o_rem_re <= RW'(n_mag_re);
                o_rem_im <= RW'(n_mag_im);
            end
        end
    end

    assign o_valid = r3_valid;

endmodule

// ----- rtl/cna_div_step.sv -----
// One restoring-division step for both parts: one quotient bit per stage.
module cna_div_step #(
    parameter int unsigned WORD_BITS = cna_pkg::WORD_BITS_DEF,
    parameter int unsigned FRAC_BITS = cna_pkg::FRAC_BITS_DEF,
    parameter int unsigned SHIFT     = 0
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_en,
    input  logic                                                i_valid,
    input  logic                                                i_dz,
    input  logic                                                i_neg_re,
    input  logic                                                i_neg_im,
    input  logic [cna_pkg::rem_bits(WORD_BITS, FRAC_BITS)-1:0] i_rem_re,
    input  logic [cna_pkg::rem_bits(WORD_BITS, FRAC_BITS)-1:0] i_rem_im,
    input  logic [cna_pkg::den_bits(WORD_BITS, FRAC_BITS)-1:0] i_den,
    input  logic [WORD_BITS+1:0]                                i_q_re,
    input  logic [WORD_BITS+1:0]                                i_q_im,
    output logic                                                o_valid,
    output logic                                                o_dz,
    output logic                                                o_neg_re,
    output logic                                                o_neg_im,
    output logic [cna_pkg::rem_bits(WORD_BITS, FRAC_BITS)-1:0] o_rem_re,
    output logic [cna_pkg::rem_bits(WORD_BITS, FRAC_BITS)-1:0] o_rem_im,
    output logic [cna_pkg::den_bits(WORD_BITS, FRAC_BITS)-1:0] o_den,
    output logic [WORD_BITS+1:0]                                o_q_re,
    output logic [WORD_BITS+1:0]                                o_q_im
);
    localparam int RW = cna_pkg::rem_bits(WORD_BITS, FRAC_BITS);
    localparam int QW = WORD_BITS + 2;
    localparam logic [QW-1:0] QBIT = QW'(1) << SHIFT;

    logic [RW-1:0] dsh;
    logic          ge_re, ge_im;

    assign dsh   = RW'(i_den) << SHIFT;
    assign ge_re = i_rem_re >= dsh;
    assign ge_im = i_rem_im >= dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_dz     <= i_dz;
            o_neg_re <= i_neg_re;
            o_neg_im <= i_neg_im;
            o_den    <= i_den;
            o_rem_re <= ge_re ? i_rem_re - dsh : i_rem_re;
            o_rem_im <= ge_im ? i_rem_im - dsh : i_rem_im;
            o_q_re   <= ge_re ? (i_q_re | QBIT) : i_q_re;
            o_q_im   <= ge_im ? (i_q_im | QBIT) : i_q_im;
        end
    end

endmodule

// ----- rtl/cna_back.sv -----
// Back end: restore sign, clamp to the word range, hold the result for the sink.
module cna_back #(
    parameter int unsigned WORD_BITS = cna_pkg::WORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic                                i_dz,
    input  logic                                i_neg_re,
    input  logic                                i_neg_im,
    input  logic [WORD_BITS+1:0]                i_q_re,
    input  logic [WORD_BITS+1:0]                i_q_im,
    output logic                                o_valid,
    output logic signed [cna_pkg::IO_BITS-1:0]  o_res_real,
    output logic signed [cna_pkg::IO_BITS-1:0]  o_res_imag,
    output logic                                o_dz,
    output logic                                o_sat
);
    localparam int QW = WORD_BITS + 2;
    localparam logic [QW-1:0] LIM_POS = QW'((64'd1 << (WORD_BITS - 1)) - 64'd1);
    localparam logic [QW-1:0] LIM_NEG = QW'(64'd1 << (WORD_BITS - 1));
    localparam logic signed [WORD_BITS-1:0] MAXV = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] MINV = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic                        sat_re, sat_im;
    logic signed [WORD_BITS-1:0] v_re, v_im;

    assign sat_re = i_neg_re ? (i_q_re > LIM_NEG) : (i_q_re > LIM_POS);
    assign sat_im = i_neg_im ? (i_q_im > LIM_NEG) : (i_q_im > LIM_POS);

    always_comb begin
        if (sat_re) begin
            v_re = i_neg_re ? MINV : MAXV;
        end else begin
            v_re = i_neg_re ? -$signed(i_q_re[WORD_BITS-1:0]) : $signed(i_q_re[WORD_BITS-1:0]);
        end
        if (sat_im) begin
            v_im = i_neg_im ? MINV : MAXV;
        end else begin
            v_im = i_neg_im ? -$signed(i_q_im[WORD_BITS-1:0]) : $signed(i_q_im[WORD_BITS-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res_real <= cna_pkg::IO_BITS'(v_re);
            o_res_imag <= cna_pkg::IO_BITS'(v_im);
            o_dz       <= i_dz;
            o_sat      <= sat_re || sat_im;
        end
    end

endmodule

// ----- rtl/complex_number_alu_core.sv -----
// Throughput: one request per cycle unless stalled; the divider is one quotient bit per stage, so it
// never loops and every mode streams through the same fixed-depth pipeline.
// Stall: the whole pipeline holds while the result register is full and not taken.
// Reset: synchronous, active low; clears all stage valid bits and holds off requests,
// the data path is not reset.
module complex_number_alu_core #(
    parameter int unsigned WORD_BITS = cna_pkg::WORD_BITS_DEF,
    parameter int unsigned FRAC_BITS = cna_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cna_req_if.sink     i_req,
    cna_rsp_if.source   o_rsp
);
    localparam int RW   = cna_pkg::rem_bits(WORD_BITS, FRAC_BITS);
    localparam int DENW = cna_pkg::den_bits(WORD_BITS, FRAC_BITS);
    localparam int QW   = WORD_BITS + 2;
    // one division stage per quotient bit, top bit catches overflow
    localparam int NSTEP = WORD_BITS + 2;

    // Advance everything when the result register is free or being drained.
    logic en;
    logic out_valid;

    assign en          = !out_valid || o_rsp.ready;
    // Take no request while reset is held; it would be dropped.
    assign i_req.ready = en && i_rst_n;

    // Chain signals: index 0 is the front end output, index NSTEP the last step.
    logic            c_valid  [0:NSTEP];
    logic            c_dz     [0:NSTEP];
    logic            c_neg_re [0:NSTEP];
    logic            c_neg_im [0:NSTEP];
    logic [RW-1:0]   c_rem_re [0:NSTEP];
    logic [RW-1:0]   c_rem_im [0:NSTEP];
    logic [DENW-1:0] c_den    [0:NSTEP];
    logic [QW-1:0]   c_q_re   [0:NSTEP];
    logic [QW-1:0]   c_q_im   [0:NSTEP];

    // Operands are the low word bits of each field, sign-extended.
    cna_front #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_req.valid),
        .i_mode   (i_req.mode),
        .i_ar     ($signed(i_req.a_real[WORD_BITS-1:0])),
        .i_ai     ($signed(i_req.a_imag[WORD_BITS-1:0])),
        .i_br     ($signed(i_req.b_real[WORD_BITS-1:0])),
        .i_bi     ($signed(i_req.b_imag[WORD_BITS-1:0])),
        .o_valid  (c_valid[0]),
        .o_dz     (c_dz[0]),
        .o_neg_re (c_neg_re[0]),
        .o_neg_im (c_neg_im[0]),
        .o_rem_re (c_rem_re[0]),
        .o_rem_im (c_rem_im[0]),
        .o_den    (c_den[0])
    );

    assign c_q_re[0] = '0;
    assign c_q_im[0] = '0;

    // Quotient bits from the top (overflow bit) down to bit zero.
    for (genvar k = 0; k < NSTEP; k++) begin : g_div
        cna_div_step #(
            .WORD_BITS (WORD_BITS),
            .FRAC_BITS (FRAC_BITS),
            .SHIFT     (NSTEP - 1 - k)
        ) u_step (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_valid  (c_valid[k]),
            .i_dz     (c_dz[k]),
            .i_neg_re (c_neg_re[k]),
            .i_neg_im (c_neg_im[k]),
            .i_rem_re (c_rem_re[k]),
            .i_rem_im (c_rem_im[k]),
            .i_den    (c_den[k]),
            .i_q_re   (c_q_re[k]),
            .i_q_im   (c_q_im[k]),
            .o_valid  (c_valid[k+1]),
            .o_dz     (c_dz[k+1]),
            .o_neg_re (c_neg_re[k+1]),
            .o_neg_im (c_neg_im[k+1]),
            .o_rem_re (c_rem_re[k+1]),
            .o_rem_im (c_rem_im[k+1]),
            .o_den    (c_den[k+1]),
            .o_q_re   (c_q_re[k+1]),
            .o_q_im   (c_q_im[k+1])
        );
    end

    // Final remainders and divisor are not needed past the last step.
    cna_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (c_valid[NSTEP]),
        .i_dz       (c_dz[NSTEP]),
        .i_neg_re   (c_neg_re[NSTEP]),
        .i_neg_im   (c_neg_im[NSTEP]),
        .i_q_re     (c_q_re[NSTEP]),
        .i_q_im     (c_q_im[NSTEP]),
        .o_valid    (out_valid),
        .o_res_real (o_rsp.res_real),
        .o_res_imag (o_rsp.res_imag),
        .o_dz       (o_rsp.divide_by_zero),
        .o_sat      (o_rsp.saturated)
    );

    assign o_rsp.valid = out_valid;

    // Limits of the word range, sign-extended to the port width.
    localparam logic signed [WORD_BITS-1:0] MAXW = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] MINW = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [cna_pkg::IO_BITS-1:0] MAXO = cna_pkg::IO_BITS'(MAXW);
    localparam logic signed [cna_pkg::IO_BITS-1:0] MINO = cna_pkg::IO_BITS'(MINW);

    // A zero-divisor result passes the left operand and can never clamp.
    a_dz_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.divide_by_zero |-> !o_rsp.saturated)
        else $error("zero-divisor result flagged as saturated");

    // A clamped result carries a range limit in at least one part.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.saturated |->
            (o_rsp.res_real == MAXO) || (o_rsp.res_real == MINO) ||
            (o_rsp.res_imag == MAXO) || (o_rsp.res_imag == MINO))
        else $error("saturated flag without a limit value");

    // A blocked result must stall the request side.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |-> !i_req.ready)
        else $error("request accepted while the pipeline is stalled");

endmodule

// ----- tb/sv/tb_complex_number_alu_core.sv -----
// Self-checking testbench for the complex ALU core: predicts each result and compares it.
module tb_complex_number_alu_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FB = cna_pkg::FRAC_BITS_DEF;
    localparam int unsigned WB = cna_pkg::WORD_BITS_DEF;
    localparam int LATENCY = WB + 6;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] a_real;
        logic signed [31:0] a_imag;
        logic signed [31:0] b_real;
        logic signed [31:0] b_imag;
    } alu_op_t;

    typedef struct packed {
        logic signed [31:0] res_real;
        logic signed [31:0] res_imag;
        logic               divide_by_zero;
        logic               saturated;
    } alu_res_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cna_req_if req_ch();
    cna_rsp_if rsp_ch();

    complex_number_alu_core uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    alu_res_t expected_results[$];
    int       fail_count = 0;
    bit       hold_off = 1'b0;     // long receiver stall, driven by its own process
    bit       rsp_random = 1'b1;

    // Clamp a wide signed value to the word range; raise the flag when clamped.
    function automatic logic signed [31:0] clamp_part(input logic signed [127:0] v,
                                                      inout logic flag);
        logic signed [127:0] maxv;
        logic signed [127:0] minv;
        maxv = (128'sd1 <<< (WB - 1)) - 1;
        minv = -maxv - 1;
        if (v > maxv) begin
            flag = 1'b1;
            return maxv[31:0];
        end
        if (v < minv) begin
            flag = 1'b1;
            return minv[31:0];
        end
        return v[31:0];
    endfunction

    // Truncating division toward zero; SV signed division already truncates.
    function automatic logic signed [127:0] trunc_div(input logic signed [127:0] num,
                                                      input logic signed [127:0] den);
        return num / den;
    endfunction

    function automatic alu_res_t compute_result(input alu_op_t op);
        alu_res_t r;
        logic signed [127:0] ar, ai, br, bi, re, im, den;
        logic sat;
        ar = op.a_real;
        ai = op.a_imag;
        br = op.b_real;
        bi = op.b_imag;
        sat = 1'b0;
        r.divide_by_zero = 1'b0;
        case (op.mode)
            cna_pkg::MODE_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            cna_pkg::MODE_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            cna_pkg::MODE_MUL: begin
                re = trunc_div(ar * br - ai * bi, 128'sd1 <<< FB);
                im = trunc_div(ar * bi + ai * br, 128'sd1 <<< FB);
            end
            default: begin
                if (br == 0 && bi == 0) begin
                    r.divide_by_zero = 1'b1;
                    re = ar;
                    im = ai;
                end else begin
                    den = br * br + bi * bi;
                    re = trunc_div((ar * br + ai * bi) <<< FB, den);
                    im = trunc_div((ai * br - ar * bi) <<< FB, den);
                end
            end
        endcase
        r.res_real = clamp_part(re, sat);
        r.res_imag = clamp_part(im, sat);
        r.saturated = sat;
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Offer one request, hold it until accepted, then queue its prediction.
    // Valid stays high after acceptance so back-to-back requests need no second drive.
    task automatic send_request(input alu_op_t op, input bit with_gaps);
        int g;
        g = with_gaps ? gap_len() : 0;
        if (g != 0) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.mode   <= op.mode;
        req_ch.a_real <= op.a_real;
        req_ch.a_imag <= op.a_imag;
        req_ch.b_real <= op.b_real;
        req_ch.b_imag <= op.b_imag;
        do @(posedge i_clk); while (!req_ch.ready);
        expected_results.push_back(compute_result(op));
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            4: return $signed($urandom_range(0, 32'hffffff)) - 32'sh800000;
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic alu_op_t rand_op();
        alu_op_t op;
        op.mode   = 2'($urandom_range(0, 3));
        op.a_real = rand_word();
        op.a_imag = rand_word();
        op.b_real = rand_word();
        op.b_imag = rand_word();
        if (op.mode == cna_pkg::MODE_DIV && $urandom_range(0, 15) == 0) begin
            op.b_real = 32'sd0;
            op.b_imag = 32'sd0;
        end
        return op;
    endfunction

    // Result sink: random ready, with an optional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            rsp_ch.ready <= 1'b0;
        end else if (rsp_random) begin
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        alu_res_t exp_r;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result real=%h imag=%h", rsp_ch.res_real, rsp_ch.res_imag);
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (rsp_ch.res_real !== exp_r.res_real) begin
                    $error("res_real expected %h actual %h", exp_r.res_real, rsp_ch.res_real);
                    fail_count++;
                end
                if (rsp_ch.res_imag !== exp_r.res_imag) begin
                    $error("res_imag expected %h actual %h", exp_r.res_imag, rsp_ch.res_imag);
                    fail_count++;
                end
                if (rsp_ch.divide_by_zero !== exp_r.divide_by_zero) begin
                    $error("divide_by_zero expected %b actual %b",
                           exp_r.divide_by_zero, rsp_ch.divide_by_zero);
                    fail_count++;
                end
                if (rsp_ch.saturated !== exp_r.saturated) begin
                    $error("saturated expected %b actual %b", exp_r.saturated, rsp_ch.saturated);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_extremes();
        logic signed [31:0] ext[5];
        alu_op_t op;
        ext = '{32'sh7fffffff, 32'sh80000000, 32'sd0, 32'sh00010000, 32'shffff0000};
        for (int m = 0; m < 4; m++) begin
            for (int k = 0; k < 5; k++) begin
                op.mode   = 2'(m);
                op.a_real = ext[k];
                op.a_imag = ext[(k + 1) % 5];
                op.b_real = ext[(k + 2) % 5];
                op.b_imag = ext[(k + 4) % 5];
                send_request(op, 1'b0);
            end
        end
        // zero divisor returns the left operand, divider paths at the top magnitude
        op = '{cna_pkg::MODE_DIV, 32'sh12345678, 32'shfedcba98, 32'sd0, 32'sd0};
        send_request(op, 1'b0);
        op = '{cna_pkg::MODE_DIV, 32'sh80000000, 32'sh80000000, 32'sd1, 32'sd0};
        send_request(op, 1'b0);
        op = '{cna_pkg::MODE_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000};
        send_request(op, 1'b0);
    endtask

    task automatic test_random_ops(input int count);
        for (int n = 0; n < count; n++) send_request(rand_op(), 1'b1);
    endtask

    // Stall the receiver for a long stretch while requests keep coming.
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (4 * LATENCY) @(posedge i_clk);
                hold_off = 1'b0;
            end
            test_random_ops(3 * LATENCY);
        join
    endtask

    task automatic test_full_rate();
        rsp_random = 1'b0;
        for (int n = 0; n < 200; n++) send_request(rand_op(), 1'b0);
        rsp_random = 1'b1;
    endtask

    initial begin
        req_ch.valid  <= 1'b0;
        req_ch.mode   <= cna_pkg::MODE_ADD;
        req_ch.a_real <= '0;
        req_ch.a_imag <= '0;
        req_ch.b_real <= '0;
        req_ch.b_imag <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_random_ops(800);
        test_backpressure();
        test_full_rate();
        test_random_ops(900);
        req_ch.valid <= 1'b0;

        // Drain, then idle before reporting.
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("simulation failed");
        $finish;
    end
endmodule

// ----- complex_number_alu_core.f -----
rtl/cna_pkg.sv
rtl/cna_if.sv
rtl/cna_front.sv
rtl/cna_div_step.sv
rtl/cna_back.sv
rtl/complex_number_alu_core.sv
tb/sv/tb_complex_number_alu_core.sv
